### hw/rtl/psched_pkg.sv
// ----------------------------------------------------------------------------
// psched_pkg
// Shared widths, sizes and controller/datapath command and status types
// of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package psched_pkg;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PROCESSES + 1);

  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned JOB_W   = 4;
  localparam int unsigned TIME_W  = 21;

  typedef struct packed {
    logic             load;
    logic             scan_init;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             acc;
    logic             decide;
    logic             emit;
    logic             last;
    logic             clear_set;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] job_count;
    logic             best_valid;
    logic             out_busy;
  } sts_t;

endpackage

### hw/rtl/psched_in_if.sv
// ----------------------------------------------------------------------------
// psched_in_if
// Job load channel: arrival, burst, priority and end-of-set mark.
// ----------------------------------------------------------------------------
interface psched_in_if import psched_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic [PRIO_W-1:0]  priority_level;
  logic               last_process;

  modport source (output valid, output arrival_time, output burst_time,
                  output priority_level, output last_process, input ready);
  modport sink   (input valid, input arrival_time, input burst_time,
                  input priority_level, input last_process, output ready);
endinterface

### hw/rtl/psched_out_if.sv
// ----------------------------------------------------------------------------
// psched_out_if
// Result channel: one item per completed job, in completion order.
// ----------------------------------------------------------------------------
interface psched_out_if import psched_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [JOB_W-1:0]  job_number;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic              last_result;

  modport source (output valid, output job_number, output completion_time,
                  output turnaround_time, output waiting_time, output last_result,
                  input ready);
  modport sink   (input valid, input job_number, input completion_time,
                  input turnaround_time, input waiting_time, input last_result,
                  output ready);
endinterface

### hw/rtl/psched_datapath.sv
// ----------------------------------------------------------------------------
// psched_datapath
// Job stores, done flags, current time, scan accumulator and result register.
// ----------------------------------------------------------------------------
module psched_datapath import psched_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [ARR_W-1:0]   arrival_time_i,
  input  logic [BURST_W-1:0] burst_time_i,
  input  logic [PRIO_W-1:0]  priority_level_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [JOB_W-1:0]   job_number_o,
  output logic [TIME_W-1:0]  completion_time_o,
  output logic [TIME_W-1:0]  turnaround_time_o,
  output logic [TIME_W-1:0]  waiting_time_o,
  output logic               last_result_o
);

  logic [ARR_W-1:0]   arr_mem   [MAX_PROCESSES];
  logic [BURST_W-1:0] burst_mem [MAX_PROCESSES];
  logic [PRIO_W-1:0]  prio_mem  [MAX_PROCESSES];

  logic [MAX_PROCESSES-1:0] done_q;
  logic [CNT_W-1:0]         count_q;
  logic [TIME_W-1:0]        time_q;

  logic [ARR_W-1:0]   rd_arr_q;
  logic [BURST_W-1:0] rd_burst_q;
  logic [PRIO_W-1:0]  rd_prio_q;
  logic               rd_done_q;
  logic [IDX_W-1:0]   rd_idx_q;

  logic               best_valid_q;
  logic [ARR_W-1:0]   best_arr_q;
  logic [BURST_W-1:0] best_burst_q;
  logic [PRIO_W-1:0]  best_prio_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [ARR_W-1:0]   min_arr_q;
  logic [TIME_W-1:0]  wt_q;

  logic               out_valid_q;
  logic [JOB_W-1:0]   job_q;
  logic [TIME_W-1:0]  ct_q;
  logic [TIME_W-1:0]  tat_q;
  logic [TIME_W-1:0]  wt_out_q;
  logic               last_q;

  logic has_room;
  logic rd_ready;
  logic rd_better;

  assign has_room  = (count_q < CNT_W'(MAX_PROCESSES));
  assign rd_ready  = !rd_done_q && (TIME_W'(rd_arr_q) <= time_q);
  assign rd_better = !best_valid_q || (rd_prio_q < best_prio_q) ||
                     ((rd_prio_q == best_prio_q) && (rd_arr_q < best_arr_q));

  // job stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      arr_mem[count_q[IDX_W-1:0]]   <= arrival_time_i;
      burst_mem[count_q[IDX_W-1:0]] <= burst_time_i;
      prio_mem[count_q[IDX_W-1:0]]  <= priority_level_i;
    end
    if (cmd_i.rd_en) begin
      rd_arr_q   <= arr_mem[cmd_i.rd_addr];
      rd_burst_q <= burst_mem[cmd_i.rd_addr];
      rd_prio_q  <= prio_mem[cmd_i.rd_addr];
      rd_done_q  <= done_q[cmd_i.rd_addr];
      rd_idx_q   <= cmd_i.rd_addr;
    end
  end

  // scan accumulator and decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      min_arr_q <= '1;
    end else if (cmd_i.acc && !rd_done_q && (rd_arr_q < min_arr_q)) begin
      min_arr_q <= rd_arr_q;
    end
    if (cmd_i.acc && rd_ready && rd_better) begin
      best_arr_q   <= rd_arr_q;
      best_burst_q <= rd_burst_q;
      best_prio_q  <= rd_prio_q;
      best_idx_q   <= rd_idx_q;
    end
    if (cmd_i.decide) begin
      wt_q <= time_q - TIME_W'(best_arr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      done_q       <= '0;
      count_q      <= '0;
      time_q       <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        best_valid_q <= 1'b0;
      end else if (cmd_i.acc && rd_ready) begin
        best_valid_q <= 1'b1;
      end
      if (cmd_i.load && has_room) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.decide) begin
        if (best_valid_q) begin
          time_q             <= time_q + TIME_W'(best_burst_q);
          done_q[best_idx_q] <= 1'b1;
        end else begin
          time_q <= TIME_W'(min_arr_q);
        end
      end
      if (cmd_i.clear_set) begin
        done_q  <= '0;
        count_q <= '0;
        time_q  <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      job_q    <= JOB_W'(best_idx_q);
      ct_q     <= time_q;
      tat_q    <= wt_q + TIME_W'(best_burst_q);
      wt_out_q <= wt_q;
      last_q   <= cmd_i.last;
    end
  end

  assign sts_o.job_count  = count_q;
  assign sts_o.best_valid = best_valid_q;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign job_number_o      = job_q;
  assign completion_time_o = ct_q;
  assign turnaround_time_o = tat_q;
  assign waiting_time_o    = wt_out_q;
  assign last_result_o     = last_q;

endmodule

### hw/rtl/psched_ctrl.sv
// ----------------------------------------------------------------------------
// psched_ctrl
// Sequencer: load, per-decision scan over stored jobs, decide, emit.
// ----------------------------------------------------------------------------
module psched_ctrl import psched_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] idx_q;
  logic             acc_q;
  logic [CNT_W-1:0] fin_q;

  logic scan_end;
  logic is_last;

  assign scan_end = (CNT_W'(idx_q) == (sts_i.job_count - CNT_W'(1)));
  assign is_last  = ((fin_q + CNT_W'(1)) == sts_i.job_count);

  always_comb begin
    cmd_o           = '0;
    cmd_o.rd_addr   = idx_q;
    cmd_o.acc       = acc_q;
    cmd_o.last      = is_last;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load      = in_valid_i;
        cmd_o.scan_init = in_valid_i && in_last_i;
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DECIDE: begin
        cmd_o.decide    = 1'b1;
        cmd_o.scan_init = !sts_i.best_valid;
      end
      S_EMIT: begin
        cmd_o.emit      = !sts_i.out_busy;
        cmd_o.clear_set = !sts_i.out_busy && is_last;
        cmd_o.scan_init = !sts_i.out_busy && !is_last;
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      acc_q   <= 1'b0;
      fin_q   <= '0;
    end else begin
      acc_q <= (state_q == S_SCAN);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_last_i) begin
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (sts_i.best_valid) begin
            state_q <= S_EMIT;
          end else begin
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (!sts_i.out_busy) begin
            if (is_last) begin
              fin_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              fin_q   <= fin_q + CNT_W'(1);
              idx_q   <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/priority_schedule_timing.sv
// ----------------------------------------------------------------------------
// priority_schedule_timing
// Non-preemptive priority scheduler: loads jobs, then emits one result item
// per job in completion order.
//
//   channel  dir  fields
//   in_i     in   arrival_time, burst_time, priority_level, last_process
//   out_o    out  job_number, completion_time, turnaround_time, waiting_time,
//                 last_result
//
// Load items are taken whenever the scheduler is idle. After the last item, each
// decision scans the N stored jobs through a single registered store read
// port, plus one more scan whenever time must jump to an arrival.
// No items are taken while a set is being scheduled. Reset clears the job
// count, done flags and time; no clearing pass. A stalled result holds in the
// output register; the next load item is taken once the final result is in it.
// ----------------------------------------------------------------------------
module priority_schedule_timing import psched_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  psched_in_if.sink     in_i,
  psched_out_if.source  out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  psched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_process),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psched_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .arrival_time_i    (in_i.arrival_time),
    .burst_time_i      (in_i.burst_time),
    .priority_level_i  (in_i.priority_level),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .job_number_o      (out_o.job_number),
    .completion_time_o (out_o.completion_time),
    .turnaround_time_o (out_o.turnaround_time),
    .waiting_time_o    (out_o.waiting_time),
    .last_result_o     (out_o.last_result)
  );

endmodule

### hw/rtl/psched_chk.sv
// ----------------------------------------------------------------------------
// psched_chk
// Port-level checks of the priority scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psched_chk import psched_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_last_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [JOB_W-1:0]  job_number_i,
  input logic [TIME_W-1:0] completion_time_i,
  input logic [TIME_W-1:0] turnaround_time_i,
  input logic [TIME_W-1:0] waiting_time_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(job_number_i)
      && $stable(completion_time_i))
    else $error("result changed under stall");

  // end of set stops loading
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("item taken while scheduling");

  // plain loads keep the channel open
  a_load_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("load stalled");

  // times are ordered
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (turnaround_time_i >= waiting_time_i)
      && (completion_time_i >= turnaround_time_i))
    else $error("result times out of order");

  // results only come out of a scheduling run
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result while loading");

endmodule

bind priority_schedule_timing psched_chk u_psched_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_last_i         (in_i.last_process),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .job_number_i      (out_o.job_number),
  .completion_time_i (out_o.completion_time),
  .turnaround_time_i (out_o.turnaround_time),
  .waiting_time_i    (out_o.waiting_time)
);
